// ===== sv/hcbd_pkg.sv =====
// Package for the HTTP chunked body decoder.
// Holds parse phase codes, result kinds, error codes, the result beat type
// and the hex digit decoder. No dependencies.
package hcbd_pkg;

   localparam int SIZE_BITS_DEFAULT = 32;

   localparam logic [3:0] PH_FIRST_DIGIT  = 4'd0;
   localparam logic [3:0] PH_SIZE         = 4'd1;
   localparam logic [3:0] PH_AFTER_SIZE   = 4'd2;
   localparam logic [3:0] PH_DATA         = 4'd3;
   localparam logic [3:0] PH_AFTER_DATA   = 4'd4;
   localparam logic [3:0] PH_TRAILER      = 4'd5;
   localparam logic [3:0] PH_TRAILER_LINE = 4'd6;
   localparam logic [3:0] PH_DONE         = 4'd7;
   localparam logic [3:0] PH_FAILED       = 4'd8;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_END     = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic [1:0] ERR_LENGTH   = 2'd0;
   localparam logic [1:0] ERR_NEWLINE  = 2'd1;
   localparam logic [1:0] ERR_EARLY    = 2'd2;
   localparam logic [1:0] ERR_OVERFLOW = 2'd3;

   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_F  = 8'h66;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_F  = 8'h46;
   localparam logic [7:0] HEX_TEN    = 8'h0a;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic [7:0] data;
      logic [1:0] code;
   } result_type;

   // {is_hex, value}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         v = c - CHAR_0;
         return {1'b1, v[3:0]};
      end
      if (c >= CHAR_LO_A && c <= CHAR_LO_F) begin
         v = c - CHAR_LO_A + HEX_TEN;
         return {1'b1, v[3:0]};
      end
      if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
         v = c - CHAR_UP_A + HEX_TEN;
         return {1'b1, v[3:0]};
      end
      return 5'd0;
   endfunction

endpackage

// ===== sv/hcbd_step.sv =====
// Per-byte parse step of the chunked body decoder: next phase, next size
// count and the result beat for one input byte. Uses hcbd_pkg.
module hcbd_step #(
   parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEFAULT
) (
   input  logic [3:0]           phase,
   input  logic [SIZE_BITS-1:0] bytes_left,
   input  logic [7:0]           in_byte,
   input  logic                 upstream_end,
   output logic [3:0]           phase_next,
   output logic [SIZE_BITS-1:0] bytes_left_next,
   output hcbd_pkg::result_type result
);

   logic [4:0]           hex;
   logic [SIZE_BITS-1:0] acc;

   always_comb begin
      hex             = hcbd_pkg::hex_decode(in_byte);
      acc             = (phase == hcbd_pkg::PH_FIRST_DIGIT) ? '0 : bytes_left;
      phase_next      = phase;
      bytes_left_next = bytes_left;
      result          = '0;

      if (phase == hcbd_pkg::PH_DONE || phase == hcbd_pkg::PH_FAILED) begin
         phase_next = phase;
      end else if (phase > hcbd_pkg::PH_FAILED) begin
         phase_next = hcbd_pkg::PH_FAILED;
      end else if (upstream_end) begin
         phase_next  = hcbd_pkg::PH_FAILED;
         result.valid = 1'b1;
         result.kind  = hcbd_pkg::KIND_ERROR;
         result.code  = hcbd_pkg::ERR_EARLY;
      end else begin
         unique case (phase) inside
            hcbd_pkg::PH_FIRST_DIGIT, hcbd_pkg::PH_SIZE: begin
               if (!hex[4]) begin
                  if (phase == hcbd_pkg::PH_SIZE) begin
                     phase_next = hcbd_pkg::PH_AFTER_SIZE;
                  end else begin
                     phase_next   = hcbd_pkg::PH_FAILED;
                     result.valid = 1'b1;
                     result.kind  = hcbd_pkg::KIND_ERROR;
                     result.code  = hcbd_pkg::ERR_LENGTH;
                  end
               end else if (acc[SIZE_BITS-1 -: 4] != 4'd0) begin
                  phase_next   = hcbd_pkg::PH_FAILED;
                  result.valid = 1'b1;
                  result.kind  = hcbd_pkg::KIND_ERROR;
                  result.code  = hcbd_pkg::ERR_OVERFLOW;
               end else begin
                  phase_next      = hcbd_pkg::PH_SIZE;
                  bytes_left_next = {acc[SIZE_BITS-5:0], hex[3:0]};
               end
            end
            hcbd_pkg::PH_AFTER_SIZE: begin
               if (in_byte == hcbd_pkg::CHAR_LF) begin
                  phase_next = (bytes_left == '0) ? hcbd_pkg::PH_TRAILER
                                                  : hcbd_pkg::PH_DATA;
               end
            end
            hcbd_pkg::PH_DATA: begin
               bytes_left_next = bytes_left - 1'b1;
               if (bytes_left_next == '0) begin
                  phase_next = hcbd_pkg::PH_AFTER_DATA;
               end
               result.valid = 1'b1;
               result.kind  = hcbd_pkg::KIND_PAYLOAD;
               result.data  = in_byte;
            end
            hcbd_pkg::PH_AFTER_DATA: begin
               if (in_byte == hcbd_pkg::CHAR_LF) begin
                  phase_next = hcbd_pkg::PH_FIRST_DIGIT;
               end else if (in_byte != hcbd_pkg::CHAR_CR) begin
                  phase_next   = hcbd_pkg::PH_FAILED;
                  result.valid = 1'b1;
                  result.kind  = hcbd_pkg::KIND_ERROR;
                  result.code  = hcbd_pkg::ERR_NEWLINE;
               end
            end
            hcbd_pkg::PH_TRAILER: begin
               if (in_byte == hcbd_pkg::CHAR_LF) begin
                  phase_next   = hcbd_pkg::PH_DONE;
                  result.valid = 1'b1;
                  result.kind  = hcbd_pkg::KIND_END;
               end else if (in_byte != hcbd_pkg::CHAR_CR) begin
                  phase_next = hcbd_pkg::PH_TRAILER_LINE;
               end
            end
            hcbd_pkg::PH_TRAILER_LINE: begin
               if (in_byte == hcbd_pkg::CHAR_LF) begin
                  phase_next = hcbd_pkg::PH_TRAILER;
               end
            end
            default: begin
               phase_next = hcbd_pkg::PH_FAILED;
            end
         endcase
      end
   end

endmodule

// ===== sv/http_chunked_body_decoder.sv =====
// HTTP/1.1 chunked body decoder: one raw byte per beat in, payload bytes,
// end-of-body or error beats out. Path: input register -> step -> result
// register -> rsp_valid; throughput 1 byte per cycle while rsp_stall does
// not hold a pending result. Sync active-high reset returns to "expect size
// digit" with a zero count; after end of body or an error all input is
// dropped until reset. Uses hcbd_pkg and hcbd_step.
module http_chunked_body_decoder #(
   parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_upstream_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_error_code
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 in_end_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_kind_ff;
   logic [7:0]           rsp_byte_ff;
   logic [1:0]           rsp_code_ff;
   logic [3:0]           phase_ff, phase_in;
   logic [SIZE_BITS-1:0] left_ff, left_in;
   logic                 out_free;
   logic                 step_fire;
   logic                 req_take;
   hcbd_pkg::result_type res;

   hcbd_step #(.SIZE_BITS(SIZE_BITS)) u_step (
      .phase           (phase_ff),
      .bytes_left      (left_ff),
      .in_byte         (in_byte_ff),
      .upstream_end    (in_end_ff),
      .phase_next      (phase_in),
      .bytes_left_next (left_in),
      .result          (res)
   );

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign step_fire    = in_valid_ff && out_free;
   assign req_stall    = in_valid_ff && !out_free;
   assign req_take     = req_valid && !req_stall;
   assign in_valid_in  = req_take || (in_valid_ff && !out_free);
   assign rsp_valid_in = out_free ? (step_fire && res.valid) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= hcbd_pkg::PH_FIRST_DIGIT;
         left_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step_fire) begin
            phase_ff <= phase_in;
            left_ff  <= left_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_in_byte;
         in_end_ff  <= req_upstream_end;
      end
      if (step_fire && res.valid) begin
         rsp_kind_ff <= res.kind;
         rsp_byte_ff <= res.data;
         rsp_code_ff <= res.code;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_error_code = rsp_code_ff;

   a_error_sticks: assert property (@(posedge clock) disable iff (reset)
      step_fire && res.valid && res.kind == hcbd_pkg::KIND_ERROR
      |=> phase_ff == hcbd_pkg::PH_FAILED)
      else $error("error beat did not park the parser");

   a_data_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == hcbd_pkg::PH_DATA |-> left_ff != '0)
      else $error("data phase with zero bytes left");

   a_quiet_after_end: assert property (@(posedge clock) disable iff (reset)
      step_fire && (phase_ff == hcbd_pkg::PH_DONE || phase_ff == hcbd_pkg::PH_FAILED)
      |-> !res.valid)
      else $error("beat produced after end or error");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff != hcbd_pkg::KIND_PAYLOAD |-> rsp_byte_ff == 8'd0)
      else $error("non-payload beat carries a byte");

endmodule

// ===== test/tb_http_chunked_body_decoder.sv =====
`timescale 1ns / 1ps
// Testbench for http_chunked_body_decoder: a chunked body stream with bursty
// beats and a stalling receiver, checked beat by beat by a scoreboard class.
// Depends on hcbd_pkg and the decoder RTL.
module tb_http_chunked_body_decoder;

   localparam int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEFAULT;
   localparam int TARGET_BEATS = 1300;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic [1:0] kind;
      logic [7:0] data;
      logic [1:0] code;
   } decoded_beat_type;

   typedef enum int unsigned {
      FIN_END_BODY,
      FIN_BAD_LENGTH,
      FIN_BAD_NEWLINE,
      FIN_EARLY_END,
      FIN_SIZE_OVERFLOW
   } body_finish_type;

   class decoder_scoreboard;
      logic [3:0] phase;
      logic [SIZE_BITS-1:0] remaining;
      decoded_beat_type expected[$];
      int errors;

      function new();
         phase = hcbd_pkg::PH_FIRST_DIGIT;
         remaining = '0;
         errors = 0;
      endfunction

      static function bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
         v = '0;
         if (c >= hcbd_pkg::CHAR_0 && c <= hcbd_pkg::CHAR_9) begin
            v = 4'(c - hcbd_pkg::CHAR_0);
         end else if (c >= hcbd_pkg::CHAR_LO_A && c <= hcbd_pkg::CHAR_LO_F) begin
            v = 4'(c - hcbd_pkg::CHAR_LO_A + hcbd_pkg::HEX_TEN);
         end else if (c >= hcbd_pkg::CHAR_UP_A && c <= hcbd_pkg::CHAR_UP_F) begin
            v = 4'(c - hcbd_pkg::CHAR_UP_A + hcbd_pkg::HEX_TEN);
         end else begin
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function void push(logic [1:0] kind, logic [7:0] data, logic [1:0] code);
         decoded_beat_type b;
         b.kind = kind;
         b.data = data;
         b.code = code;
         expected.push_back(b);
      endfunction

      function void abort(logic [1:0] code);
         phase = hcbd_pkg::PH_FAILED;
         push(hcbd_pkg::KIND_ERROR, 8'd0, code);
      endfunction

      function int pending();
         return expected.size();
      endfunction

      // next decoder state and expected beat for one accepted input beat
      function void note_input(logic [7:0] c, logic ended);
         logic [3:0] nib;
         bit is_hex;
         if (phase == hcbd_pkg::PH_DONE || phase == hcbd_pkg::PH_FAILED) return;
         if (phase > hcbd_pkg::PH_FAILED) begin
            phase = hcbd_pkg::PH_FAILED;
            return;
         end
         if (ended) begin
            abort(hcbd_pkg::ERR_EARLY);
            return;
         end
         is_hex = hex_nibble(c, nib);
         case (phase) inside
            hcbd_pkg::PH_FIRST_DIGIT, hcbd_pkg::PH_SIZE: begin
               if (!is_hex) begin
                  if (phase == hcbd_pkg::PH_SIZE) phase = hcbd_pkg::PH_AFTER_SIZE;
                  else abort(hcbd_pkg::ERR_LENGTH);
               end else begin
                  if (phase == hcbd_pkg::PH_FIRST_DIGIT) begin
                     phase = hcbd_pkg::PH_SIZE;
                     remaining = '0;
                  end
                  if (remaining[SIZE_BITS-1 -: 4] != 0) abort(hcbd_pkg::ERR_OVERFLOW);
                  else remaining = {remaining[SIZE_BITS-5:0], nib};
               end
            end
            hcbd_pkg::PH_AFTER_SIZE: begin
               if (c == hcbd_pkg::CHAR_LF) begin
                  phase = (remaining == 0) ? hcbd_pkg::PH_TRAILER : hcbd_pkg::PH_DATA;
               end
            end
            hcbd_pkg::PH_DATA: begin
               remaining = remaining - 1'b1;
               if (remaining == 0) phase = hcbd_pkg::PH_AFTER_DATA;
               push(hcbd_pkg::KIND_PAYLOAD, c, hcbd_pkg::ERR_LENGTH);
            end
            hcbd_pkg::PH_AFTER_DATA: begin
               if (c == hcbd_pkg::CHAR_LF) phase = hcbd_pkg::PH_FIRST_DIGIT;
               else if (c != hcbd_pkg::CHAR_CR) abort(hcbd_pkg::ERR_NEWLINE);
            end
            hcbd_pkg::PH_TRAILER: begin
               if (c == hcbd_pkg::CHAR_LF) begin
                  phase = hcbd_pkg::PH_DONE;
                  push(hcbd_pkg::KIND_END, 8'd0, hcbd_pkg::ERR_LENGTH);
               end else if (c != hcbd_pkg::CHAR_CR) begin
                  phase = hcbd_pkg::PH_TRAILER_LINE;
               end
            end
            default: begin
               if (c == hcbd_pkg::CHAR_LF) phase = hcbd_pkg::PH_TRAILER;
            end
         endcase
      endfunction

      function void check(logic [1:0] kind, logic [7:0] data, logic [1:0] code);
         decoded_beat_type want;
         if (expected.size() == 0) begin
            $error("unexpected rsp beat: kind %0d, out_byte %02h, error_code %0d",
                   kind, data, code);
            errors++;
            return;
         end
         want = expected.pop_front();
         if (kind !== want.kind) begin
            $error("rsp_kind: expected %0d, actual %0d", want.kind, kind);
            errors++;
         end
         if (data !== want.data) begin
            $error("rsp_out_byte: expected %02h, actual %02h", want.data, data);
            errors++;
         end
         if (code !== want.code) begin
            $error("rsp_error_code: expected %0d, actual %0d", want.code, code);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'd0;
   logic       req_upstream_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_error_code;

   decoder_scoreboard sb;
   int cycles = 0;
   int beats_sent = 0;
   int burst_left = 0;
   int stall_mode = 0;
   int stall_left = 0;

   http_chunked_body_decoder u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_upstream_end (req_upstream_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_error_code   (rsp_error_code)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(16, 96);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_stall = 1'b0;
         1: rsp_stall = ($urandom_range(0, 3) == 0);
         2: rsp_stall = ($urandom_range(0, 3) != 0);
         default: rsp_stall = ((stall_left % 8) < 5);
      endcase
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_http_chunked_body_decoder: FAIL");
         $finish;
      end else if (!reset && rsp_valid && !rsp_stall) begin
         sb.check(rsp_kind, rsp_out_byte, rsp_error_code);
      end
   end

   function automatic logic [7:0] rand_not_lf();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == hcbd_pkg::CHAR_LF);
      return c;
   endfunction

   function automatic logic [7:0] rand_not_crlf();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == hcbd_pkg::CHAR_LF || c == hcbd_pkg::CHAR_CR);
      return c;
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_beat(input logic [7:0] c, input logic ended = 1'b0);
      if (burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 24);
      end
      req_valid = 1'b1;
      req_in_byte = c;
      req_upstream_end = ended;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_input(c, ended);
      beats_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic send_size(input int unsigned value, input int lead);
      int digits;
      logic [3:0] nib;
      logic [7:0] c;
      digits = 1;
      while (digits < 8 && (value >> (4 * digits)) != 0) digits++;
      repeat (lead) send_beat(hcbd_pkg::CHAR_0);
      for (int i = digits - 1; i >= 0; i--) begin
         nib = 4'(value >> (4 * i));
         if (nib < hcbd_pkg::HEX_TEN) begin
            c = hcbd_pkg::CHAR_0 + nib;
         end else begin
            c = ($urandom_range(0, 1) ? hcbd_pkg::CHAR_UP_A : hcbd_pkg::CHAR_LO_A)
                + nib - hcbd_pkg::HEX_TEN;
         end
         send_beat(c);
      end
   endtask

   task automatic send_chunk(input int unsigned size, input bit bad_tail);
      send_size(size, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
      case ($urandom_range(0, 7))
         0: begin
            send_beat(";");
            repeat ($urandom_range(0, 6)) send_beat(rand_not_lf());
            send_beat(hcbd_pkg::CHAR_CR);
            send_beat(hcbd_pkg::CHAR_LF);
         end
         1: begin
            send_beat(hcbd_pkg::CHAR_LF);
            repeat ($urandom_range(0, 3)) send_beat(rand_not_lf());
            send_beat(hcbd_pkg::CHAR_LF);
         end
         default: begin
            send_beat(hcbd_pkg::CHAR_CR);
            send_beat(hcbd_pkg::CHAR_LF);
         end
      endcase
      if (size != 0) begin
         repeat (size) send_beat(8'($urandom_range(0, 255)));
         if (bad_tail) begin
            send_beat(rand_not_crlf());
         end else begin
            case ($urandom_range(0, 5))
               0: send_beat(hcbd_pkg::CHAR_LF);
               1: begin
                  send_beat(hcbd_pkg::CHAR_CR);
                  send_beat(hcbd_pkg::CHAR_CR);
                  send_beat(hcbd_pkg::CHAR_LF);
               end
               default: begin
                  send_beat(hcbd_pkg::CHAR_CR);
                  send_beat(hcbd_pkg::CHAR_LF);
               end
            endcase
         end
      end
   endtask

   initial begin
      body_finish_type fin;
      int unsigned size;
      logic [7:0] c;
      logic [3:0] nib;
      sb = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // single-byte chunk with all ones payload
      send_size(1, 0);
      send_beat(hcbd_pkg::CHAR_CR);
      send_beat(hcbd_pkg::CHAR_LF);
      send_beat(8'hff);
      send_beat(hcbd_pkg::CHAR_CR);
      send_beat(hcbd_pkg::CHAR_LF);
      // leading zeros, extension, repeated CR after data
      send_size(2, 3);
      send_beat(";");
      send_beat("e");
      send_beat(hcbd_pkg::CHAR_CR);
      send_beat(hcbd_pkg::CHAR_LF);
      send_beat(8'h00);
      send_beat(8'h80);
      send_beat(hcbd_pkg::CHAR_CR);
      send_beat(hcbd_pkg::CHAR_CR);
      send_beat(hcbd_pkg::CHAR_LF);
      // bare LF ends the size and is swallowed, so the next LF opens data
      send_size(1, 0);
      send_beat(hcbd_pkg::CHAR_LF);
      send_beat(";");
      send_beat(hcbd_pkg::CHAR_LF);
      send_beat(hcbd_pkg::CHAR_LF);
      send_beat(hcbd_pkg::CHAR_LF);
      drain();

      while (beats_sent < TARGET_BEATS) begin
         case ($urandom_range(0, 9)) inside
            [0:5]: size = $urandom_range(1, 8);
            [6:8]: size = $urandom_range(9, 40);
            default: size = $urandom_range(41, 200);
         endcase
         send_chunk(size, 1'b0);
         if ($urandom_range(0, 9) == 0) drain();
      end

      // only one terminal condition per reset
      fin = body_finish_type'($urandom_range(0, 4));
      case (fin)
         FIN_END_BODY: begin
            send_chunk(0, 1'b0);
            repeat ($urandom_range(0, 2)) begin
               send_beat(rand_not_crlf());
               repeat ($urandom_range(0, 8)) send_beat(rand_not_lf());
               if ($urandom_range(0, 1)) send_beat(hcbd_pkg::CHAR_CR);
               send_beat(hcbd_pkg::CHAR_LF);
            end
            if ($urandom_range(0, 1)) send_beat(hcbd_pkg::CHAR_CR);
            send_beat(hcbd_pkg::CHAR_LF);
         end
         FIN_BAD_LENGTH: begin
            do c = 8'($urandom_range(0, 255));
            while (decoder_scoreboard::hex_nibble(c, nib));
            send_beat(c);
         end
         FIN_BAD_NEWLINE: begin
            send_chunk($urandom_range(1, 16), 1'b1);
         end
         FIN_EARLY_END: begin
            if ($urandom_range(0, 1)) send_size($urandom_range(1, 255), 0);
         end
         default: begin
            send_beat("1");
            repeat (8) send_beat(hcbd_pkg::CHAR_0 + 8'($urandom_range(0, 9)));
         end
      endcase
      // everything after the end or an error is dropped
      send_beat(8'($urandom_range(0, 255)), 1'b1);
      repeat (11) send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (sb.errors == 0) begin
         $display("tb_http_chunked_body_decoder: PASS");
      end else begin
         $display("tb_http_chunked_body_decoder: FAIL");
      end
      $finish;
   end

endmodule
